// File: sv/cgfo_pkg.sv
package cgfo_pkg;
	localparam logic [1:0] KIND_CAR = 2'd0;
	localparam logic [1:0] KIND_DSU = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_BUSERR = 2'd3;

	localparam logic [10:0] ID_CTRL_ACC = 11'h710;
	localparam logic [10:0] ID_CTRL_AEB = 11'h711;
	localparam logic [10:0] ID_DSU_ACC = 11'h343;
	localparam logic [10:0] ID_DSU_AEB = 11'h344;
	localparam logic [10:0] ID_HEARTBEAT = 11'h2FF;

	localparam logic [2:0] FAULT_OK = 3'd0;
	localparam logic [2:0] FAULT_CSUM = 3'd1;
	localparam logic [2:0] FAULT_BUS = 3'd3;
	localparam logic [2:0] FAULT_POWERUP = 3'd4;
	localparam logic [2:0] FAULT_DSU_TIMEOUT = 3'd5;
	localparam logic [2:0] FAULT_AEB_CTRL = 3'd7;

	localparam logic [7:0] TIMEOUT_RESET = 8'd50;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0] kind;
		logic [10:0] frame_id;
		logic [3:0] frame_len;
		logic [63:0] frame_data;
		logic mailbox_free;
		logic csum_ok;
	} item_t;

	typedef struct packed {
		logic dest_bus;
		logic [10:0] out_id;
		logic [3:0] out_len;
		logic [63:0] out_data;
		logic [2:0] fault_code;
		logic [1:0] mode_bits;
	} result_t;

	function automatic logic [7:0] csum8(input logic [10:0] id, input logic [63:0] d);
		logic [7:0] s;
		s = 8'd8 + {5'd0, id[10:8]} + id[7:0];
		for (int i = 0; i < 7; i++) begin
			s = s + d[8*i +: 8];
		end
		return s;
	endfunction
endpackage

// File: sv/can_gateway_frame_override.sv
// Each input is written into the front queue and, when it emits a frame, registered into the back-end result.
// Throughput: one item per cycle while the output is not stalled, set by the back-end update.
// A two-entry queue between front and back absorbs output stalls.
// Reset (arst_n low) clears queue, output and state; timeout limit returns to 50.
module can_gateway_frame_override import cgfo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [10:0] frame_id,
	input logic [3:0] frame_len,
	input logic [63:0] frame_data,
	input logic mailbox_free,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	output logic out_valid,
	input logic out_stall,
	output logic dest_bus,
	output logic [10:0] out_id,
	output logic [3:0] out_len,
	output logic [63:0] out_data,
	output logic [2:0] fault_code,
	output logic [1:0] mode_bits
);
	logic q_valid, q_pop;
	item_t q_item;
	result_t res;

	cgfo_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .frame_id, .frame_len,
		.frame_data, .mailbox_free, .q_valid, .q_pop, .q_item
	);

	cgfo_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .q_valid, .q_pop, .q_item,
		.out_valid, .out_stall, .res
	);

	assign dest_bus = res.dest_bus;
	assign out_id = res.out_id;
	assign out_len = res.out_len;
	assign out_data = res.out_data;
	assign fault_code = res.fault_code;
	assign mode_bits = res.mode_bits;
endmodule

// File: sv/cgfo_front.sv
module cgfo_front import cgfo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [10:0] frame_id,
	input logic [3:0] frame_len,
	input logic [63:0] frame_data,
	input logic mailbox_free,
	output logic q_valid,
	input logic q_pop,
	output item_t q_item
);
	item_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	item_t wr;

	assign in_stall = (cnt_q == 2'(QDEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_comb begin
		wr.kind = kind;
		wr.frame_id = frame_id;
		wr.frame_len = frame_len;
		wr.frame_data = frame_data;
		wr.mailbox_free = mailbox_free;
		wr.csum_ok = (frame_data[63:56] == csum8(frame_id, frame_data));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// File: sv/cgfo_back.sv
module cgfo_back import cgfo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic q_valid,
	output logic q_pop,
	input item_t q_item,
	output logic out_valid,
	input logic out_stall,
	output result_t res
);
	logic [7:0] limit_q, dsu_sil_q, acc_sil_q, aeb_sil_q;
	logic [2:0] fault_q;
	logic [1:0] mode_q;
	logic acc_en_q, aeb_en_q, stock_q, hb_phase_q;
	logic [15:0] acc_cmd_q;
	logic [9:0] aeb_cmd_q;
	logic [3:0] hb_cnt_q;
	logic ov_q;
	result_t res_q;

	logic [7:0] n_dsu, n_acc, n_aeb;
	logic [2:0] n_fault;
	logic [1:0] n_mode;
	logic n_acc_en, n_aeb_en, n_stock, n_phase;
	logic [15:0] n_acc_cmd;
	logic [9:0] n_aeb_cmd;
	logic [3:0] n_cnt;
	logic emit, n_bus;
	logic [10:0] n_id;
	logic [3:0] n_len;
	logic [63:0] d, hb;
	logic [7:0] h2;
	item_t it;

	assign it = q_item;
	assign q_pop = q_valid && (!ov_q || !out_stall);
	assign out_valid = ov_q;
	assign res = res_q;

	always_comb begin
		n_dsu = dsu_sil_q; n_acc = acc_sil_q; n_aeb = aeb_sil_q;
		n_fault = fault_q; n_mode = mode_q;
		n_acc_en = acc_en_q; n_aeb_en = aeb_en_q; n_stock = stock_q;
		n_phase = hb_phase_q; n_acc_cmd = acc_cmd_q; n_aeb_cmd = aeb_cmd_q;
		n_cnt = hb_cnt_q;
		emit = 1'b0; n_bus = 1'b0; n_id = it.frame_id; n_len = it.frame_len;
		d = it.frame_data;
		hb = '0; h2 = '0;
		case (it.kind)
			KIND_CAR: begin
				if (it.frame_id == ID_CTRL_ACC) begin
					if (it.csum_ok) begin
						n_acc_en = 1'b1; n_acc_cmd = {d[7:0], d[15:8]};
						n_acc = '0; n_mode = mode_q | 2'b01;
					end else begin
						n_fault = FAULT_CSUM; n_acc_en = 1'b0; n_acc_cmd = '0;
					end
				end else if (it.frame_id == ID_CTRL_AEB) begin
					if (it.csum_ok) begin
						n_aeb_en = 1'b1; n_aeb_cmd = {d[7:0], d[9:8]};
						n_aeb = '0; n_mode = mode_q | 2'b10; n_fault = FAULT_AEB_CTRL;
					end else begin
						n_fault = FAULT_CSUM; n_aeb_en = 1'b0; n_aeb_cmd = '0;
					end
				end else begin
					emit = 1'b1; n_bus = 1'b1;
				end
			end
			KIND_DSU: begin
				emit = 1'b1;
				if (it.frame_id == ID_DSU_ACC) begin
					if (it.csum_ok) begin
						d[23:16] = {2'b01, d[21:16]};
						d[30] = 1'b1;
						if (acc_en_q) begin
							d[7:0] = acc_cmd_q[15:8]; d[15:8] = acc_cmd_q[7:0];
						end
						d[63:56] = csum8(it.frame_id, d);
						n_dsu = '0; n_fault = FAULT_OK;
					end else begin
						n_fault = FAULT_CSUM;
					end
				end else if (it.frame_id == ID_DSU_AEB) begin
					n_stock = ({d[7:0], d[15:14]} != 10'd0);
					if (it.csum_ok) begin
						if (aeb_en_q && !n_stock) begin
							d[7:0] = aeb_cmd_q[9:2];
							d[15:8] = {aeb_cmd_q[1:0], 6'b010010};
							d[38] = 1'b1;
							d[63:56] = csum8(it.frame_id, d);
						end
					end else begin
						n_fault = FAULT_CSUM;
					end
				end
			end
			KIND_BUSERR: begin
				n_fault = FAULT_BUS;
			end
			default: begin
				h2 = {fault_q[2:0] == 3'd0 ? 4'd0 : {1'b0, fault_q}, hb_cnt_q};
				hb[15:8] = {6'd0, mode_q};
				hb[23:16] = h2;
				hb[31:24] = 8'd4 + 8'h02 + 8'hFF + {6'd0, mode_q} + h2;
				if (hb_phase_q && it.mailbox_free) begin
					emit = 1'b1; n_cnt = hb_cnt_q + 4'd1;
				end
				n_phase = ~hb_phase_q;
				n_id = ID_HEARTBEAT; n_len = 4'd4; d = hb;
				if (dsu_sil_q >= limit_q) n_fault = FAULT_DSU_TIMEOUT;
				else n_dsu = dsu_sil_q + 8'd1;
				if (acc_sil_q >= limit_q) begin
					n_acc_en = 1'b0; n_mode = n_mode & 2'b10;
				end else n_acc = acc_sil_q + 8'd1;
				if (aeb_sil_q >= limit_q) begin
					n_aeb_en = 1'b0; n_mode = n_mode & 2'b01;
				end else n_aeb = aeb_sil_q + 8'd1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q.dest_bus <= n_bus;
			res_q.out_id <= n_id;
			res_q.out_len <= n_len;
			res_q.out_data <= d;
			res_q.fault_code <= n_fault;
			res_q.mode_bits <= n_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
			fault_q <= FAULT_POWERUP;
			mode_q <= '0; acc_en_q <= 1'b0; aeb_en_q <= 1'b0; stock_q <= 1'b0;
			acc_cmd_q <= '0; aeb_cmd_q <= '0;
			dsu_sil_q <= '0; acc_sil_q <= '0; aeb_sil_q <= '0;
			hb_phase_q <= 1'b0; hb_cnt_q <= '0; ov_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (q_pop) begin
				fault_q <= n_fault; mode_q <= n_mode;
				acc_en_q <= n_acc_en; aeb_en_q <= n_aeb_en; stock_q <= n_stock;
				acc_cmd_q <= n_acc_cmd; aeb_cmd_q <= n_aeb_cmd;
				dsu_sil_q <= n_dsu; acc_sil_q <= n_acc; aeb_sil_q <= n_aeb;
				hb_phase_q <= n_phase; hb_cnt_q <= n_cnt;
				ov_q <= emit;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule

// File: dv/gateway_checker.sv
module gateway_checker import cgfo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [1:0] kind,
	input logic [10:0] frame_id,
	input logic [3:0] frame_len,
	input logic [63:0] frame_data,
	input logic mailbox_free,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic out_valid,
	input logic out_stall,
	input logic dest_bus,
	input logic [10:0] out_id,
	input logic [3:0] out_len,
	input logic [63:0] out_data,
	input logic [2:0] fault_code,
	input logic [1:0] mode_bits,
	output int fail_count,
	output int frames_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] limit_q;
	logic [2:0] fault_q;
	logic [1:0] mode_q;
	logic acc_en_q, aeb_en_q, stock_aeb_q, hb_phase_q;
	logic [15:0] acc_cmd_q;
	logic [9:0] aeb_cmd_q;
	logic [7:0] dsu_quiet_q, acc_quiet_q, aeb_quiet_q;
	logic [3:0] hb_count_q;
	result_t tx_frames[$];

	assign frames_pending = tx_frames.size();

	function automatic logic [7:0] frame_sum(input logic [10:0] id, input logic [63:0] d,
			input int n);
		logic [7:0] s;
		s = 8'(n) + {5'd0, id[10:8]} + id[7:0];
		for (int i = 0; i < n - 1; i++) s = s + d[8*i +: 8];
		return s;
	endfunction

	task automatic send_frame(input logic bus, input logic [10:0] id, input logic [3:0] len,
			input logic [63:0] d);
		result_t r;
		r.dest_bus = bus;
		r.out_id = id;
		r.out_len = len;
		r.out_data = d;
		r.fault_code = fault_q;
		r.mode_bits = mode_q;
		tx_frames.push_back(r);
	endtask

	task automatic route_event();
		logic [63:0] d;
		logic ok, hb;
		logic [9:0] stock;
		d = frame_data;
		ok = d[63:56] == frame_sum(frame_id, d, 8);
		hb = 1'b0;
		case (kind)
			KIND_CAR: begin
				if (frame_id == ID_CTRL_ACC) begin
					if (ok) begin
						acc_en_q = 1'b1;
						acc_cmd_q = {d[7:0], d[15:8]};
						acc_quiet_q = '0;
						mode_q[0] = 1'b1;
					end else begin
						fault_q = FAULT_CSUM;
						acc_en_q = 1'b0;
						acc_cmd_q = '0;
					end
				end else if (frame_id == ID_CTRL_AEB) begin
					if (ok) begin
						aeb_en_q = 1'b1;
						aeb_cmd_q = {d[7:0], d[9:8]};
						aeb_quiet_q = '0;
						mode_q[1] = 1'b1;
						fault_q = FAULT_AEB_CTRL;
					end else begin
						aeb_en_q = 1'b0;
						aeb_cmd_q = '0;
						fault_q = FAULT_CSUM;
					end
				end else send_frame(1'b1, frame_id, frame_len, d);
			end
			KIND_DSU: begin
				if (frame_id == ID_DSU_ACC) begin
					if (ok) begin
						d[23:16] = {2'b01, d[21:16]};
						d[30] = 1'b1;
						if (acc_en_q) begin
							d[7:0] = acc_cmd_q[15:8];
							d[15:8] = acc_cmd_q[7:0];
						end
						d[63:56] = frame_sum(frame_id, d, 8);
						dsu_quiet_q = '0;
						fault_q = FAULT_OK;
					end else fault_q = FAULT_CSUM;
				end else if (frame_id == ID_DSU_AEB) begin
					stock = {d[7:0], d[15:14]};
					stock_aeb_q = stock != 10'd0;
					if (ok) begin
						if (aeb_en_q && !stock_aeb_q) begin
							d[7:0] = aeb_cmd_q[9:2];
							d[15:8] = {aeb_cmd_q[1:0], 6'b010010};
							d[38] = 1'b1;
							d[63:56] = frame_sum(frame_id, d, 8);
						end
					end else fault_q = FAULT_CSUM;
				end
				send_frame(1'b0, frame_id, frame_len, d);
			end
			KIND_BUSERR: fault_q = FAULT_BUS;
			default: begin
				if (hb_phase_q && mailbox_free) begin
					d = '0;
					d[15:8] = {6'd0, mode_q};
					d[23:16] = {1'b0, fault_q, hb_count_q};
					d[31:24] = frame_sum(ID_HEARTBEAT, d, 4);
					hb_count_q = hb_count_q + 4'd1;
					hb = 1'b1;
				end
				hb_phase_q = !hb_phase_q;
				if (dsu_quiet_q >= limit_q) fault_q = FAULT_DSU_TIMEOUT;
				else dsu_quiet_q++;
				if (acc_quiet_q >= limit_q) begin
					acc_en_q = 1'b0;
					mode_q[0] = 1'b0;
				end else acc_quiet_q++;
				if (aeb_quiet_q >= limit_q) begin
					aeb_en_q = 1'b0;
					mode_q[1] = 1'b0;
				end else aeb_quiet_q++;
				if (hb) send_frame(1'b0, ID_HEARTBEAT, 4'd4, d);
			end
		endcase
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			limit_q = TIMEOUT_RESET;
			fault_q = FAULT_POWERUP;
			mode_q = '0;
			acc_en_q = 1'b0;
			aeb_en_q = 1'b0;
			stock_aeb_q = 1'b0;
			hb_phase_q = 1'b0;
			acc_cmd_q = '0;
			aeb_cmd_q = '0;
			dsu_quiet_q = '0;
			acc_quiet_q = '0;
			aeb_quiet_q = '0;
			hb_count_q = '0;
			fail_count = 0;
			tx_frames.delete();
		end else begin
			if (cfg_we) limit_q = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (tx_frames.size() == 0) report("unexpected frame", 64'(out_id), '0);
				else begin
					w = tx_frames.pop_front();
					if (dest_bus !== w.dest_bus)
						report("dest_bus", 64'(dest_bus), 64'(w.dest_bus));
					if (out_id !== w.out_id) report("out_id", 64'(out_id), 64'(w.out_id));
					if (out_len !== w.out_len)
						report("out_len", 64'(out_len), 64'(w.out_len));
					if (out_data !== w.out_data) report("out_data", out_data, w.out_data);
					if (fault_code !== w.fault_code)
						report("fault_code", 64'(fault_code), 64'(w.fault_code));
					if (mode_bits !== w.mode_bits)
						report("mode_bits", 64'(mode_bits), 64'(w.mode_bits));
				end
			end
			if (in_valid && !in_stall) route_event();
		end
	end
endmodule

// File: dv/testbench.sv
module testbench import cgfo_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0, arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic [1:0] kind = '0;
	logic [10:0] frame_id = '0;
	logic [3:0] frame_len = '0;
	logic [63:0] frame_data = '0;
	logic mailbox_free = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic dest_bus;
	logic [10:0] out_id;
	logic [3:0] out_len;
	logic [63:0] out_data;
	logic [2:0] fault_code;
	logic [1:0] mode_bits;
	int fail_count, frames_pending;

	can_gateway_frame_override dut (.*);
	gateway_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] seal(input logic [10:0] id, input logic [63:0] d);
		logic [7:0] s;
		s = 8'd8 + {5'd0, id[10:8]} + id[7:0];
		for (int i = 0; i < 7; i++) s = s + d[8*i +: 8];
		d[63:56] = s;
		return d;
	endfunction

	task automatic push_event(input logic [1:0] k, input logic [10:0] id, input logic [3:0] len,
			input logic [63:0] d, input logic mb);
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		frame_id <= id;
		frame_len <= len;
		frame_data <= d;
		mailbox_free <= mb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_event();
		logic [63:0] d;
		logic [10:0] id;
		int r;
		d = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 12) begin
			id = $urandom_range(0, 1) ? ID_CTRL_ACC : ID_CTRL_AEB;
			push_event(KIND_CAR, id, 4'($urandom_range(0, 15)),
					($urandom_range(0, 5) != 0 ? seal(id, d) : d), 1'b0);
		end else if (r < 30) begin
			id = $urandom_range(0, 1) ? ID_DSU_ACC : ID_DSU_AEB;
			if ($urandom_range(0, 1)) d[15:6] = '0;
			push_event(KIND_DSU, id, 4'($urandom_range(0, 15)),
					($urandom_range(0, 5) != 0 ? seal(id, d) : d), 1'($urandom));
		end else if (r < 45) push_event(KIND_CAR, 11'($urandom), 4'($urandom_range(0, 15)), d,
				1'($urandom));
		else if (r < 55) push_event(KIND_DSU, 11'($urandom), 4'($urandom_range(0, 15)), d,
				1'($urandom));
		else if (r < 95) push_event(KIND_TICK, 11'($urandom), 4'($urandom), d,
				$urandom_range(0, 4) != 0);
		else push_event(KIND_BUSERR, 11'($urandom), 4'($urandom), d, 1'($urandom));
	endtask

	initial begin
		int gap;
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [63:0] d;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		d = 64'h0123_4567_89AB_CDEF;
		push_event(KIND_CAR, 11'h000, 4'd0, 64'd0, 1'b0);
		push_event(KIND_CAR, 11'h7FF, 4'd15, '1, 1'b1);
		push_event(KIND_DSU, ID_DSU_ACC, 4'd8, seal(ID_DSU_ACC, d), 1'b0);
		push_event(KIND_CAR, ID_CTRL_ACC, 4'd8, seal(ID_CTRL_ACC, 64'h12AB), 1'b0);
		push_event(KIND_DSU, ID_DSU_ACC, 4'd8, seal(ID_DSU_ACC, '1), 1'b0);
		push_event(KIND_CAR, ID_CTRL_AEB, 4'd8, seal(ID_CTRL_AEB, 64'h03FF), 1'b0);
		push_event(KIND_DSU, ID_DSU_AEB, 4'd8, seal(ID_DSU_AEB, 64'h0F00_0000_0000_003F), 1'b0);
		push_event(KIND_DSU, ID_DSU_AEB, 4'd8, seal(ID_DSU_AEB, 64'hFF), 1'b0);
		push_event(KIND_DSU, ID_DSU_AEB, 4'd8, d, 1'b0);
		push_event(KIND_DSU, ID_DSU_ACC, 4'd8, d, 1'b0);
		push_event(KIND_CAR, ID_CTRL_ACC, 4'd8, d, 1'b0);
		push_event(KIND_CAR, ID_CTRL_AEB, 4'd8, d, 1'b0);
		push_event(KIND_BUSERR, 11'd0, 4'd0, 64'd0, 1'b0);
		for (int i = 0; i < 6; i++) push_event(KIND_TICK, 11'd0, 4'd0, 64'd0, i != 3);
		set_limit(8'd0);
		push_event(KIND_CAR, ID_CTRL_ACC, 4'd8, seal(ID_CTRL_ACC, 64'h5), 1'b0);
		for (int i = 0; i < 4; i++) push_event(KIND_TICK, 11'd0, 4'd0, 64'd0, 1'b1);
		set_limit(8'd255);
		for (int i = 0; i < 150; i++) random_event();
		drain();
		for (int i = 0; i < 100; i++) random_event();
		set_limit(8'd3);
		for (int i = 0; i < 100; i++) random_event();
		set_limit(8'($urandom_range(1, 20)));
		for (int i = 0; i < 100; i++) random_event();
		drain();
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule

// File: sim.f
sv/cgfo_pkg.sv
sv/cgfo_front.sv
sv/cgfo_back.sv
sv/can_gateway_frame_override.sv
dv/gateway_checker.sv
dv/testbench.sv
